>>> sv/vertex_view_transform_project_top_assert.svh
// Assertion macros used by the checker file of the vertex transform block.
// Depends on nothing; the including module supplies clk and rst.
`ifndef VERTEX_VIEW_TRANSFORM_PROJECT_TOP_ASSERT_SVH
`define VERTEX_VIEW_TRANSFORM_PROJECT_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define VVT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define VVT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/vvt_pkg.sv
// Shared constants, types and helpers of the vertex view transform block.
// Depends on nothing; used by every RTL module of the block.
package vvt_pkg;

  localparam int SCREEN_WIDTH_DEF  = 720;
  localparam int SCREEN_HEIGHT_DEF = 720;
  localparam int FRAC_BITS_DEF     = 16;
  localparam int SCALE_FRAC        = 16;
  localparam int TRIG_FRAC         = 14;
  localparam int QUOT_BITS         = 41;
  localparam logic [QUOT_BITS-1:0] QUOT_CAP = QUOT_BITS'(1) << (QUOT_BITS - 1);

  localparam int IDX_W = 3;
  localparam logic [IDX_W-1:0] REG_CAM_OFF_X  = 3'd0;
  localparam logic [IDX_W-1:0] REG_CAM_OFF_Y  = 3'd1;
  localparam logic [IDX_W-1:0] REG_CAM_OFF_Z  = 3'd2;
  localparam logic [IDX_W-1:0] REG_PITCH      = 3'd3;
  localparam logic [IDX_W-1:0] REG_YAW        = 3'd4;
  localparam logic [IDX_W-1:0] REG_ROLL       = 3'd5;
  localparam logic [IDX_W-1:0] REG_PROJ_SCALE = 3'd6;

  localparam logic [31:0] ANGLE_RESET = 32'h4000_0000;
  localparam logic [30:0] SCALE_RESET = 31'd158217;

  // Per-item data that rides alongside the quotient pipeline.
  typedef struct packed {
    logic        front;
    logic [31:0] depth;
    logic        neg_x;
    logic        neg_y;
  } sb_t;

  function automatic logic signed [31:0] sat_to_32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      r = -32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

>>> sv/vvt_rotate.sv
// One plane rotation by a packed Q2.14 cosine/sine pair, two register stages.
// Depends on vvt_pkg.
module vvt_rotate #(
  parameter int IW  = 34,
  parameter int SBW = 34
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic signed [IW-1:0] a,
  input  logic signed [IW-1:0] b,
  input  logic [31:0]          cos_sin,
  input  logic [SBW-1:0]       sb_in,
  output logic                 out_valid,
  output logic signed [IW+2:0] a_out,
  output logic signed [IW+2:0] b_out,
  output logic [SBW-1:0]       sb_out
);
  localparam int PW = IW + 16;
  localparam int SW = PW + 1;
  localparam int OW = IW + 3;
  localparam logic signed [SW-1:0] RND = SW'(1) << (vvt_pkg::TRIG_FRAC - 1);

  logic signed [15:0] c, s;
  logic signed [PW-1:0] p_ac, p_bs, p_as, p_bc;
  logic [SBW-1:0] sb_mid;
  logic v_mid;
  logic signed [SW-1:0] sum_a, sum_b;

  assign c = cos_sin[31:16];
  assign s = cos_sin[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v_mid     <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v_mid     <= in_valid;
      out_valid <= v_mid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_ac   <= PW'(a) * PW'(c);
      p_bs   <= PW'(b) * PW'(s);
      p_as   <= PW'(a) * PW'(s);
      p_bc   <= PW'(b) * PW'(c);
      sb_mid <= sb_in;
      a_out  <= OW'(sum_a >>> vvt_pkg::TRIG_FRAC);
      b_out  <= OW'(sum_b >>> vvt_pkg::TRIG_FRAC);
      sb_out <= sb_mid;
    end
  end

  // Round half up: add half an LSB, then floor by arithmetic shift.
  assign sum_a = SW'(p_ac) - SW'(p_bs) + RND;
  assign sum_b = SW'(p_as) + SW'(p_bc) + RND;

endmodule

>>> sv/vvt_quot.sv
// Pipelined restoring divider for |a|*scale/depth, one quotient bit per stage.
// Depends on vvt_pkg.
module vvt_quot #(
  parameter int FRAC_BITS = vvt_pkg::FRAC_BITS_DEF,
  parameter int SBW       = 1
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic                           in_valid,
  input  logic [31:0]                    a_mag,
  input  logic [30:0]                    depth,
  input  logic [30:0]                    scale,
  input  logic [SBW-1:0]                 sb_in,
  output logic                           out_valid,
  output logic [vvt_pkg::QUOT_BITS-1:0]  quot,
  output logic [SBW-1:0]                 sb_out
);
  localparam int QB    = vvt_pkg::QUOT_BITS;
  localparam int K_UP  = (FRAC_BITS >= vvt_pkg::SCALE_FRAC) ?
                         FRAC_BITS - vvt_pkg::SCALE_FRAC : 0;
  localparam int K_DN  = (FRAC_BITS < vvt_pkg::SCALE_FRAC) ?
                         vvt_pkg::SCALE_FRAC - FRAC_BITS : 0;
  localparam int NUM_W = 63;
  localparam int NW    = NUM_W + K_UP;
  localparam int DSW   = 31 + QB;
  localparam int RW    = (NW > DSW) ? NW : DSW;

  logic [NUM_W-1:0] num;
  logic [30:0]      d_m;
  logic [SBW-1:0]   sb_m;
  logic             v_m;
  logic [RW-1:0]    nsh;

  logic [RW-1:0]    rem [QB];
  logic [30:0]      dd  [QB];
  logic [QB-1:0]    q   [QB+1];
  logic             ovf [QB+1];
  logic [SBW-1:0]   sb  [QB+1];
  logic             v   [QB+1];

  assign nsh = (RW'(num) << K_UP) >> K_DN;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_m  <= 1'b0;
      v[0] <= 1'b0;
    end else if (en) begin
      v_m  <= in_valid;
      v[0] <= v_m;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num    <= NUM_W'(a_mag) * NUM_W'(scale);
      d_m    <= depth;
      sb_m   <= sb_in;
      rem[0] <= nsh;
      dd[0]  <= d_m;
      q[0]   <= '0;
      ovf[0] <= nsh >= (RW'(d_m) << QB);
      sb[0]  <= sb_m;
    end
  end

  for (genvar j = 0; j < QB; j++) begin : g_step
    localparam int SH = QB - 1 - j;
    logic [RW-1:0] dsh;
    logic          take;
    assign dsh  = RW'(dd[j]) << SH;
    assign take = rem[j] >= dsh;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[j+1] <= 1'b0;
      end else if (en) begin
        v[j+1] <= v[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        q[j+1]   <= {q[j][QB-2:0], take};
        ovf[j+1] <= ovf[j];
        sb[j+1]  <= sb[j];
      end
    end

    if (j < QB - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem[j+1] <= take ? rem[j] - dsh : rem[j];
          dd[j+1]  <= dd[j];
        end
      end
    end
  end

  assign out_valid = v[QB];
  assign sb_out    = sb[QB];
  assign quot      = (ovf[QB] || q[QB] > vvt_pkg::QUOT_CAP) ? vvt_pkg::QUOT_CAP : q[QB];

endmodule

>>> sv/vvt_project.sv
// Screen mapping: quotient times half the screen size, centered and saturated.
// Depends on vvt_pkg.
module vvt_project #(
  parameter int SCREEN_WIDTH  = vvt_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = vvt_pkg::SCREEN_HEIGHT_DEF,
  parameter int FRAC_BITS     = vvt_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [vvt_pkg::QUOT_BITS-1:0] quot_x,
  input  logic [vvt_pkg::QUOT_BITS-1:0] quot_y,
  input  vvt_pkg::sb_t                  sb_in,
  output logic                          out_valid,
  output logic                          in_front,
  output logic signed [31:0]            view_depth,
  output logic signed [31:0]            screen_x,
  output logic signed [31:0]            screen_y
);
  localparam int QB  = vvt_pkg::QUOT_BITS;
  localparam int WW  = $clog2(SCREEN_WIDTH + 1);
  localparam int HW  = $clog2(SCREEN_HEIGHT + 1);
  localparam int MW  = QB + ((WW > HW) ? WW : HW);
  localparam int SW  = MW + 2;
  localparam logic signed [SW-1:0] HALF_W = SW'((64'(SCREEN_WIDTH) << FRAC_BITS) >> 1);
  localparam logic signed [SW-1:0] HALF_H = SW'((64'(SCREEN_HEIGHT) << FRAC_BITS) >> 1);

  logic [MW-1:0] prod_x, prod_y;
  vvt_pkg::sb_t  sb_p;
  logic          v_p;
  logic signed [SW-1:0] mag_x, mag_y, pos_x, pos_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_p       <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v_p       <= in_valid;
      out_valid <= v_p;
    end
  end

  assign mag_x = SW'(prod_x >> 1);
  assign mag_y = SW'(prod_y >> 1);
  assign pos_x = sb_p.neg_x ? HALF_W + mag_x : HALF_W - mag_x;
  assign pos_y = sb_p.neg_y ? HALF_H - mag_y : HALF_H + mag_y;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_x     <= MW'(quot_x) * MW'(SCREEN_WIDTH);
      prod_y     <= MW'(quot_y) * MW'(SCREEN_HEIGHT);
      sb_p       <= sb_in;
      in_front   <= sb_p.front;
      view_depth <= sb_p.depth;
      screen_x   <= sb_p.front ? vvt_pkg::sat_to_32(64'(pos_x)) : 32'sd0;
      screen_y   <= sb_p.front ? vvt_pkg::sat_to_32(64'(pos_y)) : 32'sd0;
    end
  end

endmodule

>>> sv/vertex_view_transform_project_top.sv
// Vertex view transform and perspective projection, fully pipelined.
// Each accepted input item yields one result item; one item is accepted
// per cycle while the output side takes results. Most of the pipeline is
// the 41-stage quotient pipeline, one bit per stage.
// rst is synchronous: it clears all stage valid bits and restores the
// camera, angle and scale registers to their documented reset values.
module vertex_view_transform_project_top #(
  parameter int SCREEN_WIDTH  = vvt_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = vvt_pkg::SCREEN_HEIGHT_DEF,
  parameter int FRAC_BITS     = vvt_pkg::FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      wr_en,
  input  logic [vvt_pkg::IDX_W-1:0] wr_index,
  input  logic [31:0]               wr_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [31:0]        vertex_x,
  input  logic signed [31:0]        vertex_y,
  input  logic signed [31:0]        vertex_z,
  input  logic signed [31:0]        obj_off_x,
  input  logic signed [31:0]        obj_off_y,
  input  logic signed [31:0]        obj_off_z,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      in_front,
  output logic signed [31:0]        view_depth,
  output logic signed [31:0]        screen_x,
  output logic signed [31:0]        screen_y
);
  // The whole pipeline moves as one: every stage advances when the output
  // register is empty or its item is being taken. A stall freezes all stages,
  // so nothing is lost or repeated.
  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // Configuration registers. The user must write only while the pipe is empty; the block does not enforce it.
  logic signed [31:0] cam_off_x, cam_off_y, cam_off_z;
  logic [31:0]        pitch_cos_sin, yaw_cos_sin, roll_cos_sin;
  logic [30:0]        proj_scale;

  always_ff @(posedge clk) begin
    if (rst) begin
      cam_off_x     <= '0;
      cam_off_y     <= '0;
      cam_off_z     <= '0;
      pitch_cos_sin <= vvt_pkg::ANGLE_RESET;
      yaw_cos_sin   <= vvt_pkg::ANGLE_RESET;
      roll_cos_sin  <= vvt_pkg::ANGLE_RESET;
      proj_scale    <= vvt_pkg::SCALE_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        vvt_pkg::REG_CAM_OFF_X:  cam_off_x     <= wr_data;
        vvt_pkg::REG_CAM_OFF_Y:  cam_off_y     <= wr_data;
        vvt_pkg::REG_CAM_OFF_Z:  cam_off_z     <= wr_data;
        vvt_pkg::REG_PITCH:      pitch_cos_sin <= wr_data;
        vvt_pkg::REG_YAW:        yaw_cos_sin   <= wr_data;
        vvt_pkg::REG_ROLL:       roll_cos_sin  <= wr_data;
        vvt_pkg::REG_PROJ_SCALE: proj_scale    <= wr_data[30:0];
        default: ;
      endcase
    end
  end

  // Stage 1: world placement plus camera offset. Three 32-bit terms need 34 bits.
  logic signed [33:0] px, py, pz;
  logic               v_s1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_s1 <= 1'b0;
    end else if (adv) begin
      v_s1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      px <= 34'(vertex_x) + 34'(cam_off_x) + 34'(obj_off_x);
      py <= 34'(vertex_y) + 34'(cam_off_y) + 34'(obj_off_y);
      pz <= 34'(vertex_z) + 34'(cam_off_z) - 34'(obj_off_z);
    end
  end

  // Pitch about x: (y, z) -> (y1, z1). The x coordinate rides along.
  logic signed [36:0] y1, z1;
  logic [33:0]        px_p;
  logic               v_p;

  vvt_rotate #(.IW(34), .SBW(34)) u_pitch (
    .clk(clk), .rst(rst), .en(adv), .in_valid(v_s1),
    .a(py), .b(pz), .cos_sin(pitch_cos_sin), .sb_in(px),
    .out_valid(v_p), .a_out(y1), .b_out(z1), .sb_out(px_p)
  );

  // Roll about z: (x, y1) -> (x2, y2). z1 rides along.
  logic signed [39:0] x2, y2;
  logic [36:0]        z1_r;
  logic               v_r;

  vvt_rotate #(.IW(37), .SBW(37)) u_roll (
    .clk(clk), .rst(rst), .en(adv), .in_valid(v_p),
    .a(37'(signed'(px_p))), .b(y1), .cos_sin(roll_cos_sin), .sb_in(z1),
    .out_valid(v_r), .a_out(x2), .b_out(y2), .sb_out(z1_r)
  );

  // Yaw about y: (x2, z1) -> (x3, z3). y2 rides along.
  logic signed [42:0] x3, z3;
  logic [39:0]        y2_y;
  logic               v_y;

  vvt_rotate #(.IW(40), .SBW(40)) u_yaw (
    .clk(clk), .rst(rst), .en(adv), .in_valid(v_r),
    .a(x2), .b(40'(signed'(z1_r))), .cos_sin(yaw_cos_sin), .sb_in(y2),
    .out_valid(v_y), .a_out(x3), .b_out(z3), .sb_out(y2_y)
  );

  // View stage: saturate to the 32-bit coordinate format and decide in front.
  logic signed [31:0] vx, vy, vz;
  logic               v_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_v <= 1'b0;
    end else if (adv) begin
      v_v <= v_y;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      vx <= vvt_pkg::sat_to_32(64'(x3));
      vy <= vvt_pkg::sat_to_32(64'(signed'(y2_y)));
      vz <= vvt_pkg::sat_to_32(64'(z3));
    end
  end

  // Magnitudes for the dividers. A depth that is not positive gives a
  // meaningless quotient, which the projection stage discards.
  logic signed [32:0] nx, ny;
  logic [31:0]        mag_x, mag_y;
  vvt_pkg::sb_t       sb_v, sb_q;
  logic               v_q;
  logic [vvt_pkg::QUOT_BITS-1:0] quot_x, quot_y;

  assign nx    = -33'(vx);
  assign ny    = -33'(vy);
  assign mag_x = vx[31] ? nx[31:0] : vx;
  assign mag_y = vy[31] ? ny[31:0] : vy;

  assign sb_v.front = (vz > 32'sd0);
  assign sb_v.depth = vz;
  assign sb_v.neg_x = vx[31];
  assign sb_v.neg_y = vy[31];

  vvt_quot #(.FRAC_BITS(FRAC_BITS), .SBW($bits(vvt_pkg::sb_t))) u_quot_x (
    .clk(clk), .rst(rst), .en(adv), .in_valid(v_v),
    .a_mag(mag_x), .depth(vz[30:0]), .scale(proj_scale), .sb_in(sb_v),
    .out_valid(v_q), .quot(quot_x), .sb_out(sb_q)
  );

  // The y divider runs in lockstep; its valid and sideband outputs are unused, the x ones serve both.
  vvt_quot #(.FRAC_BITS(FRAC_BITS), .SBW(1)) u_quot_y (
    .clk(clk), .rst(rst), .en(adv), .in_valid(v_v),
    .a_mag(mag_y), .depth(vz[30:0]), .scale(proj_scale), .sb_in(1'b0),
    .out_valid(), .quot(quot_y), .sb_out()
  );

  // Screen mapping and the output register.
  vvt_project #(
    .SCREEN_WIDTH(SCREEN_WIDTH), .SCREEN_HEIGHT(SCREEN_HEIGHT), .FRAC_BITS(FRAC_BITS)
  ) u_project (
    .clk(clk), .rst(rst), .en(adv), .in_valid(v_q),
    .quot_x(quot_x), .quot_y(quot_y), .sb_in(sb_q),
    .out_valid(out_valid), .in_front(in_front), .view_depth(view_depth),
    .screen_x(screen_x), .screen_y(screen_y)
  );

endmodule

>>> sv/vvt_checker.sv
// Port-level checker for the vertex transform top level, bound to it below.
// Depends on vertex_view_transform_project_top_assert.svh.
`include "vertex_view_transform_project_top_assert.svh"

module vvt_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        in_front,
  input logic [31:0] view_depth,
  input logic [31:0] screen_x,
  input logic [31:0] screen_y
);

  `VVT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(screen_x) && $stable(screen_y) && $stable(view_depth), "stalled result item changed")
  `VVT_ASSERT_NOW(a_stall_blocks, out_valid && !out_ready, !in_ready, "input taken while output stalled")
  `VVT_ASSERT_NOW(a_behind_zero, out_valid && !in_front, screen_x == 32'd0 && screen_y == 32'd0, "screen position not zero behind camera")
  `VVT_ASSERT_NOW(a_front_depth, out_valid && in_front, !view_depth[31] && view_depth != 32'd0, "in_front set with depth not positive")

endmodule

bind vertex_view_transform_project_top vvt_checker u_vvt_checker (.*);
